/* design/internet_checksum_engine_unit_macros.svh */
// Assertion macros shared by the checksum engine modules.
`ifndef INTERNET_CHECKSUM_ENGINE_UNIT_MACROS_SVH
`define INTERNET_CHECKSUM_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ICE_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("checksum engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ICE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("checksum engine: next-cycle check failed");

`endif

/* design/ice_pkg.sv */
// Shared constants, types and helper functions of the checksum engine.
package ice_pkg;

	localparam int BeatBytes   = 8;
	localparam int DataBits    = 64;
	localparam int CountBits   = 4;
	localparam int WordBits    = 16;
	localparam int HalfBits    = 32;
	localparam int UpdSumBits  = WordBits + 2;
	// A byte count at or above this figure selects the whole beat.
	localparam int FullBytes   = (BeatBytes < DataBits / 8) ? BeatBytes : DataBits / 8;

	localparam int QueueDepth   = 4;
	localparam int QueuePtrBits = $clog2(QueueDepth);
	localparam int QueueCntBits = $clog2(QueueDepth + 1);

	typedef enum logic {
		OP_BEAT   = 1'b0,
		OP_UPDATE = 1'b1
	} ice_op_t;

	// One classified word as it travels from the front end to the back end.
	typedef struct packed {
		logic                is_update;
		logic                last;
		logic                comp;
		logic [DataBits-1:0] payload;
	} ice_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ice_qstat_t;

	// Byte enables of a beat, widened to a bit mask.
	function automatic logic [DataBits-1:0] beat_mask(input logic [CountBits-1:0] count);
		logic [DataBits-1:0] m;
		m = '0;
		for (int i = 0; i < DataBits / 8; i++) begin
			if ((32'(count) >= 32'(FullBytes)) || (32'(i) < 32'(count))) begin
				m[i*8 +: 8] = '1;
			end
		end
		return m;
	endfunction

endpackage

/* design/ice_front.sv */
// Front end: takes input words, masks beat bytes, prepares update sums and queues the result.
module ice_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             operation,
	input  logic [ice_pkg::DataBits-1:0]     data,
	input  logic [ice_pkg::CountBits-1:0]    byte_count,
	input  logic                             last,
	input  logic                             complement,
	input  logic [ice_pkg::WordBits-1:0]     old_checksum,
	input  logic [ice_pkg::WordBits-1:0]     old_word,
	input  logic [ice_pkg::WordBits-1:0]     new_word,
	input  ice_pkg::ice_qstat_t              qstat,
	output logic                             push,
	output ice_pkg::ice_item_t               item
);

	logic                               valid_s1;
	ice_pkg::ice_item_t                 item_s1;
	ice_pkg::ice_item_t                 next_item;
	logic [ice_pkg::UpdSumBits-1:0]     upd_sum;
	logic                               accept;

	assign push     = valid_s1 && !qstat.full;
	assign in_stall = valid_s1 && qstat.full;
	assign accept   = in_valid && !in_stall;
	assign item     = item_s1;

	// Sum of the complemented old checksum, complemented old field and new field.
	// Each term is inverted at 16 bits before it is widened.
	assign upd_sum = {2'b0, ~old_checksum}
		+ {2'b0, ~old_word}
		+ {2'b0, new_word};

	always_comb begin
		next_item = '0;
		unique case (ice_pkg::ice_op_t'(operation))
			ice_pkg::OP_UPDATE: begin
				next_item.is_update = 1'b1;
				next_item.last      = 1'b1;
				next_item.comp      = 1'b1;
				next_item.payload   = ice_pkg::DataBits'(upd_sum);
			end
			ice_pkg::OP_BEAT: begin
				next_item.is_update = 1'b0;
				next_item.last      = last;
				next_item.comp      = complement;
				next_item.payload   = data & ice_pkg::beat_mask(byte_count);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= next_item;
		end
	end

endmodule

/* design/ice_fifo.sv */
// Short queue of classified words between the front end and the back end.
`include "internet_checksum_engine_unit_macros.svh"

module ice_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ice_pkg::ice_item_t   push_item,
	input  logic                 pop,
	output ice_pkg::ice_item_t   head_item,
	output ice_pkg::ice_qstat_t  qstat
);

	ice_pkg::ice_item_t                  mem_q [ice_pkg::QueueDepth];
	logic [ice_pkg::QueuePtrBits-1:0]    wr_ptr_q;
	logic [ice_pkg::QueuePtrBits-1:0]    rd_ptr_q;
	logic [ice_pkg::QueueCntBits-1:0]    cnt_q;

	assign head_item   = mem_q[rd_ptr_q];
	assign qstat.full  = (cnt_q == ice_pkg::QueueCntBits'(ice_pkg::QueueDepth));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == ice_pkg::QueuePtrBits'(ice_pkg::QueueDepth - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == ice_pkg::QueuePtrBits'(ice_pkg::QueueDepth - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	`ICE_ASSERT_IMP(a_no_pop_when_empty, clk, arst_n, pop, !qstat.empty)
	`ICE_ASSERT_IMP(a_no_push_when_full, clk, arst_n, push, !qstat.full)

endmodule

/* design/ice_back.sv */
// Back end: end-around accumulation, two folding stages and the output register.
`include "internet_checksum_engine_unit_macros.svh"

module ice_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ice_pkg::ice_item_t            head_item,
	input  ice_pkg::ice_qstat_t           qstat,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ice_pkg::WordBits-1:0]  checksum
);

	logic [ice_pkg::DataBits-1:0]   acc_q;
	logic                           valid_s1;
	logic [ice_pkg::DataBits-1:0]   sum_s1;
	logic                           comp_s1;
	logic                           valid_s2;
	logic [ice_pkg::HalfBits-1:0]   sum_s2;
	logic                           comp_s2;
	logic                           out_valid_q;
	logic [ice_pkg::WordBits-1:0]   checksum_q;

	logic                           adv_o;
	logic                           adv2;
	logic                           adv1;
	logic                           emits;

	logic [ice_pkg::DataBits:0]     acc_sum;
	logic [ice_pkg::DataBits-1:0]   acc_inc;
	logic [ice_pkg::DataBits-1:0]   acc_new;
	logic [ice_pkg::HalfBits:0]     f32_sum;
	logic [ice_pkg::HalfBits-1:0]   f32_inc;
	logic [ice_pkg::HalfBits-1:0]   f32;
	logic [ice_pkg::WordBits:0]     f16_sum;
	logic [ice_pkg::WordBits-1:0]   f16_inc;
	logic [ice_pkg::WordBits-1:0]   f16;

	assign adv_o = !out_valid_q || !out_stall;
	assign adv2  = !valid_s2 || adv_o;
	assign adv1  = !valid_s1 || adv2;
	assign emits = head_item.is_update || head_item.last;
	// A beat that only accumulates never waits for the folding stages.
	assign pop   = !qstat.empty && (!emits || adv1);

	// End-around carry by carry select: both candidate sums are formed side by side.
	assign acc_sum = {1'b0, acc_q} + {1'b0, head_item.payload};
	assign acc_inc = acc_q + head_item.payload + ice_pkg::DataBits'(1);
	assign acc_new = acc_sum[ice_pkg::DataBits] ? acc_inc : acc_sum[ice_pkg::DataBits-1:0];

	assign f32_sum = {1'b0, sum_s1[ice_pkg::DataBits-1:ice_pkg::HalfBits]}
		+ {1'b0, sum_s1[ice_pkg::HalfBits-1:0]};
	assign f32_inc = sum_s1[ice_pkg::DataBits-1:ice_pkg::HalfBits]
		+ sum_s1[ice_pkg::HalfBits-1:0] + ice_pkg::HalfBits'(1);
	assign f32 = f32_sum[ice_pkg::HalfBits] ? f32_inc : f32_sum[ice_pkg::HalfBits-1:0];

	assign f16_sum = {1'b0, sum_s2[ice_pkg::HalfBits-1:ice_pkg::WordBits]}
		+ {1'b0, sum_s2[ice_pkg::WordBits-1:0]};
	assign f16_inc = sum_s2[ice_pkg::HalfBits-1:ice_pkg::WordBits]
		+ sum_s2[ice_pkg::WordBits-1:0] + ice_pkg::WordBits'(1);
	assign f16 = f16_sum[ice_pkg::WordBits] ? f16_inc : f16_sum[ice_pkg::WordBits-1:0];

	assign out_valid = out_valid_q;
	assign checksum  = checksum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && !head_item.is_update) begin
				acc_q <= head_item.last ? '0 : acc_new;
			end
			if (pop && emits) begin
				valid_s1 <= 1'b1;
			end else if (adv2) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1 && adv2) begin
				valid_s2 <= 1'b1;
			end else if (adv_o) begin
				valid_s2 <= 1'b0;
			end
			if (valid_s2 && adv_o) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emits) begin
			sum_s1  <= head_item.is_update ? head_item.payload : acc_new;
			comp_s1 <= head_item.comp;
		end
		if (valid_s1 && adv2) begin
			sum_s2  <= f32;
			comp_s2 <= comp_s1;
		end
		if (valid_s2 && adv_o) begin
			checksum_q <= comp_s2 ? ~f16 : f16;
		end
	end

	`ICE_ASSERT_NEXT(a_last_beat_clears_sum, clk, arst_n,
		pop && !head_item.is_update && head_item.last, acc_q == '0)
	`ICE_ASSERT_NEXT(a_fold_stage_holds, clk, arst_n,
		valid_s1 && !adv2, valid_s1 && $stable(sum_s1))

endmodule

/* design/internet_checksum_engine_unit.sv */
// Top level of the ones' complement Internet checksum engine.
//
// Input channel (in_valid / in_stall): each word is either a data beat (operation
// low) or an incremental update (operation high). A beat carries eight bytes with
// the first byte in bits 7:0; bytes beyond byte_count are zeroed before they are
// added into the 64-bit running sum with end-around carry. A beat with last set
// closes the block: the sum is folded to 16 bits, inverted if complement is set,
// and the running sum is cleared. An update returns the adjusted checksum for a
// replaced 16-bit field and leaves the running sum alone.
// Output channel (out_valid / out_stall): one checksum word per last beat or update,
// in input order; beats without last return nothing.
// Throughput is one word per cycle while in_stall is low. An accepted word passes
// the input register, queue, accumulator, 64-to-32 fold and 32-to-16 fold in turn.
// A stalled receiver holds the output register; the folding stages and the
// four-entry queue then fill, after which in_stall rises. Beats that only accumulate
// keep draining while the output is held, until a last beat or update heads the queue.
// Reset (arst_n low) empties every stage and the queue and clears the running sum.
module internet_checksum_engine_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic [ice_pkg::DataBits-1:0]  data,
	input  logic [ice_pkg::CountBits-1:0] byte_count,
	input  logic                          last,
	input  logic                          complement,
	input  logic [ice_pkg::WordBits-1:0]  old_checksum,
	input  logic [ice_pkg::WordBits-1:0]  old_word,
	input  logic [ice_pkg::WordBits-1:0]  new_word,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ice_pkg::WordBits-1:0]  checksum
);

	// Classified words travel from the front end through the queue.
	ice_pkg::ice_item_t  push_item;
	ice_pkg::ice_item_t  head_item;
	ice_pkg::ice_qstat_t qstat;
	logic                push;
	logic                pop;

	ice_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.data         (data),
		.byte_count   (byte_count),
		.last         (last),
		.complement   (complement),
		.old_checksum (old_checksum),
		.old_word     (old_word),
		.new_word     (new_word),
		.qstat        (qstat),
		.push         (push),
		.item         (push_item)
	);

	ice_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.qstat     (qstat)
	);

	// The back end accumulates, folds and holds the result until it is taken.
	ice_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_item (head_item),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.checksum  (checksum)
	);

endmodule
